@@ rtl/stpp_pkg.sv @@
// ----------------------------------------------------------------------------
// stpp_pkg
// Shared types and constants of the storage target payload probe.
// ----------------------------------------------------------------------------
package stpp_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam logic [13:0] MTU_RESET = 14'd1500;
    localparam logic [13:0] MTU_CAP = 14'd9216;
    localparam logic [13:0] HDR_BYTES = 14'd36;
    localparam logic [7:0] CMD_ATA = 8'd0;
    localparam logic [7:0] CMD_QCFG = 8'd1;
    localparam logic REG_LOCAL_MAC = 1'b0;
    localparam logic REG_LINK_MTU = 1'b1;

    // One accepted header, as it travels from front to back.
    typedef struct packed {
        logic [7:0]  flags;
        logic [7:0]  command;
        logic [31:0] tag;
        logic [15:0] major;
        logic [7:0]  minor;
        logic [47:0] mac;
        logic [7:0]  sectors;
    } hdr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_PROBE,
        ST_VERDICT
    } state_t;

endpackage

@@ rtl/stpp_front.sv @@
// ----------------------------------------------------------------------------
// stpp_front
// Input side: accepts header beats into a two-entry queue.
// ----------------------------------------------------------------------------
module stpp_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  stpp_pkg::hdr_t       in_hdr,
    output logic                 q_valid,
    input  logic                 q_pop,
    output stpp_pkg::hdr_t       q_hdr
);

    stpp_pkg::hdr_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_hdr    = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_hdr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop && q_valid)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end

endmodule

@@ rtl/stpp_back.sv @@
// ----------------------------------------------------------------------------
// stpp_back
// Table search, insert, ATA update and probe/verdict emission.
// ----------------------------------------------------------------------------
module stpp_back
#(
    parameter int TABLE_ENTRIES = stpp_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [13:0]          link_mtu,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  stpp_pkg::hdr_t       q_hdr,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [143:0]         out_data,
    output logic                 out_last
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW:0] LAST_IDX = (IW + 1)'(TABLE_ENTRIES - 1);

    stpp_pkg::state_t state_reg, state_next;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [15:0] maj_reg [TABLE_ENTRIES];
    logic [7:0]  min_reg [TABLE_ENTRIES];
    logic [47:0] mac_reg [TABLE_ENTRIES];
    logic [14:0] id_reg  [TABLE_ENTRIES];
    logic [7:0]  sec_reg [TABLE_ENTRIES];
    logic [7:0]  max_reg [TABLE_ENTRIES];
    logic [14:0] next_id_reg;

    stpp_pkg::hdr_t h_reg;
    logic [IW:0]    idx_reg;
    logic           hit_reg, free_ok_reg;
    logic [IW-1:0]  hit_idx_reg, free_idx_reg;
    logic [13:0]    n_reg;
    logic [14:0]    pid_reg;

    // verdict fields worked out for the current header
    logic        v_useful_reg, v_full_reg;
    logic [7:0]  v_emax_reg, v_esec_reg;

    logic        o_valid_reg, o_probe_reg, o_useful_reg, o_full_reg, o_last_reg;
    logic [7:0]  o_emax_reg, o_esec_reg;
    logic [13:0] o_len_reg;
    logic [31:0] o_tag_reg;

    logic [IW-1:0] ix;
    logic          matches_now, pass;
    logic [13:0]   mtu_c, pay;
    logic [13:0]   n_start;
    logic          out_free;

    assign ix = idx_reg[IW-1:0];
    assign matches_now = valid_reg[ix] && maj_reg[ix] == h_reg.major
                         && min_reg[ix] == h_reg.minor && mac_reg[ix] == h_reg.mac;
    assign pass = (h_reg.flags[3:2] == 2'b10) && h_reg.tag[31];
    assign mtu_c = (link_mtu > stpp_pkg::MTU_CAP) ? stpp_pkg::MTU_CAP : link_mtu;
    assign pay = (mtu_c > stpp_pkg::HDR_BYTES) ? (mtu_c - stpp_pkg::HDR_BYTES) : 14'd0;
    assign n_start = {pay[13:9], 9'd0};
    assign out_free = !o_valid_reg || out_ready;

    assign out_valid = o_valid_reg;
    assign out_last  = o_last_reg;
    // fields from bit 0: is_probe, probe_dest_mac, probe_major, probe_minor,
    // probe_tag, probe_length, useful, table_full, entry_max_sectors, entry_sectors
    assign out_data = {7'd0, o_esec_reg, o_emax_reg, o_full_reg, o_useful_reg,
                       o_len_reg, o_tag_reg,
                       o_probe_reg ? h_reg.minor : 8'd0,
                       o_probe_reg ? h_reg.major : 16'd0,
                       o_probe_reg ? h_reg.mac : 48'd0, o_probe_reg};

    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        unique case (state_reg)
            stpp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    state_next = stpp_pkg::ST_SEARCH;
                end
            end
            stpp_pkg::ST_SEARCH:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = stpp_pkg::ST_DECIDE;
                end
            end
            stpp_pkg::ST_DECIDE:
            begin
                if (pass && h_reg.command == stpp_pkg::CMD_QCFG && !hit_reg
                    && free_ok_reg && n_start != 14'd0)
                begin
                    state_next = stpp_pkg::ST_PROBE;
                end
                else
                begin
                    state_next = stpp_pkg::ST_VERDICT;
                end
            end
            stpp_pkg::ST_PROBE:
            begin
                if (out_free && n_reg == 14'd512)
                begin
                    state_next = stpp_pkg::ST_VERDICT;
                end
            end
            stpp_pkg::ST_VERDICT:
            begin
                if (out_free)
                begin
                    state_next = stpp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stpp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stpp_pkg::ST_IDLE;
            valid_reg   <= '0;
            next_id_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == stpp_pkg::ST_DECIDE && pass
                && h_reg.command == stpp_pkg::CMD_QCFG && !hit_reg && free_ok_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                next_id_reg <= next_id_reg + 15'd1;
            end
            if ((state_reg == stpp_pkg::ST_PROBE || state_reg == stpp_pkg::ST_VERDICT)
                && out_free)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            stpp_pkg::ST_IDLE:
            begin
                h_reg <= q_hdr;
                idx_reg <= '0;
                hit_reg <= 1'b0;
                free_ok_reg <= 1'b0;
                hit_idx_reg <= '0;
                free_idx_reg <= '0;
                v_useful_reg <= 1'b0;
                v_full_reg <= 1'b0;
                v_emax_reg <= 8'd0;
                v_esec_reg <= 8'd0;
            end
            stpp_pkg::ST_SEARCH:
            begin
                if (matches_now && !hit_reg)
                begin
                    hit_reg <= 1'b1;
                    hit_idx_reg <= ix;
                end
                if (!valid_reg[ix] && !free_ok_reg)
                begin
                    free_ok_reg <= 1'b1;
                    free_idx_reg <= ix;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            stpp_pkg::ST_DECIDE:
            begin
                n_reg <= n_start;
                pid_reg <= next_id_reg;
                if (pass && h_reg.command == stpp_pkg::CMD_QCFG)
                begin
                    if (hit_reg)
                    begin
                        v_emax_reg <= max_reg[hit_idx_reg];
                        v_esec_reg <= sec_reg[hit_idx_reg];
                    end
                    else if (free_ok_reg)
                    begin
                        maj_reg[free_idx_reg] <= h_reg.major;
                        min_reg[free_idx_reg] <= h_reg.minor;
                        mac_reg[free_idx_reg] <= h_reg.mac;
                        id_reg[free_idx_reg]  <= next_id_reg;
                        sec_reg[free_idx_reg] <= h_reg.sectors;
                        max_reg[free_idx_reg] <= 8'd0;
                        v_useful_reg <= 1'b1;
                        v_esec_reg <= h_reg.sectors;
                    end
                    else
                    begin
                        v_full_reg <= 1'b1;
                    end
                end
                else if (pass && h_reg.command == stpp_pkg::CMD_ATA && hit_reg)
                begin
                    v_esec_reg <= sec_reg[hit_idx_reg];
                    if (h_reg.tag[30:16] == id_reg[hit_idx_reg])
                    begin
                        v_useful_reg <= 1'b1;
                        if (h_reg.tag[7:0] > max_reg[hit_idx_reg])
                        begin
                            max_reg[hit_idx_reg] <= h_reg.tag[7:0];
                            v_emax_reg <= h_reg.tag[7:0];
                        end
                        else
                        begin
                            v_emax_reg <= max_reg[hit_idx_reg];
                        end
                    end
                    else
                    begin
                        v_emax_reg <= max_reg[hit_idx_reg];
                    end
                end
            end
            stpp_pkg::ST_PROBE:
            begin
                // probe beats carry zero verdict fields
                if (out_free)
                begin
                    o_probe_reg <= 1'b1;
                    o_last_reg <= 1'b0;
                    o_tag_reg <= {1'b1, pid_reg, 11'd0, n_reg[13:9]};
                    o_len_reg <= n_reg + stpp_pkg::HDR_BYTES;
                    o_useful_reg <= 1'b0;
                    o_full_reg <= 1'b0;
                    o_emax_reg <= 8'd0;
                    o_esec_reg <= 8'd0;
                    n_reg <= n_reg - 14'd512;
                end
            end
            stpp_pkg::ST_VERDICT:
            begin
                if (out_free)
                begin
                    o_probe_reg <= 1'b0;
                    o_last_reg <= 1'b1;
                    o_tag_reg <= '0;
                    o_len_reg <= '0;
                    o_useful_reg <= v_useful_reg;
                    o_full_reg <= v_full_reg;
                    o_emax_reg <= v_emax_reg;
                    o_esec_reg <= v_esec_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/storage_target_payload_probe.sv @@
// A header enters the queue, then the table is scanned entry by entry
// and a decision made before the first result beat; one result beat per cycle
// after, while m_axis_tready is high. The sequential table scan handles one
// header at a time: the next leaves the queue once the last verdict is issued.
// Reset (rst_n, asynchronous): table emptied, id counter 0, MTU 1500, MAC 0.
// ----------------------------------------------------------------------------
// storage_target_payload_probe
// Tracks storage targets from response headers and requests MTU probe frames.
// ----------------------------------------------------------------------------
module storage_target_payload_probe
#(
    parameter int TABLE_ENTRIES = stpp_pkg::TABLE_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // from bit 0: frame_flags, frame_command, frame_tag, shelf_major,
    // slot_minor, source_mac, sector_count
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // from bit 0: is_probe, probe_dest_mac, probe_major, probe_minor, probe_tag,
    // probe_length, useful, table_full, entry_max_sectors, entry_sectors
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data
);

    // Station address is held but no result field carries it.
    logic [47:0] local_mac_reg;
    logic [13:0] link_mtu_reg;
    stpp_pkg::hdr_t in_hdr, q_hdr;
    logic q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg <= '0;
            link_mtu_reg  <= stpp_pkg::MTU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stpp_pkg::REG_LOCAL_MAC: local_mac_reg <= cfg_data;
                stpp_pkg::REG_LINK_MTU:  link_mtu_reg  <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    assign in_hdr.flags   = s_axis_tdata[7:0];
    assign in_hdr.command = s_axis_tdata[15:8];
    assign in_hdr.tag     = s_axis_tdata[47:16];
    assign in_hdr.major   = s_axis_tdata[63:48];
    assign in_hdr.minor   = s_axis_tdata[71:64];
    assign in_hdr.mac     = s_axis_tdata[119:72];
    assign in_hdr.sectors = s_axis_tdata[127:120];

    stpp_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_hdr   (in_hdr),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_hdr    (q_hdr)
    );

    stpp_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .link_mtu  (link_mtu_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_hdr     (q_hdr),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
